FILE: hdl/bfa_pkg.sv
// ----------------------------------------------------------------------------
// bfa_pkg: shared types and helpers of the bitmap frame allocator
// Command codes, controller states, word-scan result struct, mask helpers.
// ----------------------------------------------------------------------------
package bfa_pkg;

  localparam int unsigned WORD_W = 32;

  localparam logic [15:0] RST_LOW_START = 16'd256;
  localparam logic [15:0] RST_LOW_END   = 16'd4096;

  localparam logic REG_LOW_START = 1'b0;
  localparam logic REG_LOW_END   = 1'b1;

  typedef enum logic [2:0] {
    CMD_ALLOC_LOW  = 3'd0,
    CMD_ALLOC_HIGH = 3'd1,
    CMD_ALLOC_RUN  = 3'd2,
    CMD_FREE       = 3'd3,
    CMD_FREE_RUN   = 3'd4,
    CMD_MARK_FREE  = 3'd5,
    CMD_MARK_USED  = 3'd6
  } cmd_e;

  typedef enum logic [2:0] {
    ST_CLEAR,
    ST_IDLE,
    ST_FETCH,
    ST_SINGLE,
    ST_RUN,
    ST_MARK,
    ST_RESP
  } state_e;

  typedef struct packed {
    logic [5:0] ff_pos;   // first free bit, 32 if none
    logic [5:0] fu_pos;   // first non-free bit at or above start bit, 32 if none
    logic [5:0] top_run;  // free bits directly below the word top
    logic       win_hit;  // a window of need free bits lies in the word
    logic [4:0] win_pos;  // lowest such window
  } scan_res_t;

  // bits [n-1:0] set, n in 0..32
  function automatic logic [WORD_W-1:0] low_mask(input logic [5:0] n);
    logic [WORD_W-1:0] m;
    for (int i = 0; i < WORD_W; i++) begin
      m[i] = (6'(i) < n);
    end
    return m;
  endfunction

  // index of lowest set bit, 32 if none
  function automatic logic [5:0] first_set(input logic [WORD_W-1:0] v);
    logic [5:0] r;
    r = 6'd32;
    for (int i = WORD_W - 1; i >= 0; i--) begin
      if (v[i]) begin
        r = 6'(i);
      end
    end
    return r;
  endfunction

endpackage

FILE: hdl/bfa_bitmap_ram.sv
// ----------------------------------------------------------------------------
// bfa_bitmap_ram: used/free bitmap storage
// One write port, one read port, registered read data.
// ----------------------------------------------------------------------------
module bfa_bitmap_ram #(
  parameter int unsigned DEPTH = 1024,
  parameter int unsigned AW    = 10
) (
  input  logic                      clk_i,
  input  logic                      wr_en_i,
  input  logic [AW-1:0]             wr_addr_i,
  input  logic [bfa_pkg::WORD_W-1:0] wr_data_i,
  input  logic                      rd_en_i,
  input  logic [AW-1:0]             rd_addr_i,
  output logic [bfa_pkg::WORD_W-1:0] rd_data_o
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];
  logic [WORD_W-1:0] rd_data_q;

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      mem[wr_addr_i] <= wr_data_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (rd_en_i) begin
      rd_data_q <= mem[rd_addr_i];
    end
  end

  assign rd_data_o = rd_data_q;

endmodule

FILE: hdl/bfa_word_scan.sv
// ----------------------------------------------------------------------------
// bfa_word_scan: search of one bitmap word
// Finds first free bit, free prefix end, top free run and first fit window.
// ----------------------------------------------------------------------------
module bfa_word_scan (
  input  logic [bfa_pkg::WORD_W-1:0] free_i,   // 1 = free and inside scan range
  input  logic [4:0]                 pbit_i,   // first bit of scan range
  input  logic [15:0]                need_i,
  output bfa_pkg::scan_res_t         res_o
);
  import bfa_pkg::*;

  logic [WORD_W-1:0] g [6];
  logic [WORD_W-1:0] win;
  logic [15:0]       offs [6];
  logic [5:0]        hz;
  logic              has_zero;
  logic [5:0]        win_first;

  // g[j]: 2**j free bits starting here
  always_comb begin
    g[0] = free_i;
    for (int j = 1; j < 6; j++) begin
      g[j] = g[j-1] & (g[j-1] >> (1 << (j - 1)));
    end
  end

  // combine binary digits of need, each at the offset of the lower digits
  always_comb begin
    win = '1;
    for (int j = 0; j < 6; j++) begin
      offs[j] = need_i & ~(16'hffff << j);
      if (need_i[j]) begin
        win = win & (g[j] >> offs[j][5:0]);
      end
    end
  end

  always_comb begin
    hz       = '0;
    has_zero = 1'b0;
    for (int i = 0; i < WORD_W; i++) begin
      if (!free_i[i]) begin
        hz       = 6'(i);
        has_zero = 1'b1;
      end
    end
  end

  assign win_first = first_set(win);

  always_comb begin
    res_o.ff_pos  = first_set(free_i);
    res_o.fu_pos  = first_set(~free_i & ~low_mask({1'b0, pbit_i}));
    res_o.top_run = has_zero ? (6'd31 - hz) : 6'd32;
    res_o.win_hit = (need_i <= 16'd32) && !win_first[5];
    res_o.win_pos = win_first[4:0];
  end

endmodule

FILE: hdl/bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// bitmap_frame_allocator: page frame allocator over a used/free bitmap
// One command in, one result out, bitmap held in a word-wide RAM.
// ----------------------------------------------------------------------------
// Usage:
//   s_axis carries one command transaction (tuser = command, tdata = frame
//   number and frame count). m_axis returns exactly one result per command
//   (tdata = result frame, tuser = found). cfg writes the arena registers;
//   the user must write it only while no command is in flight (unchecked).
//   Each command is handled one at a time by a read-modify-write walk over
//   32-frame bitmap words, one word per cycle on the RAM's single read and
//   write port. Commands that touch no word go straight to their result;
//   the others fetch the first word and scan word by word, and a run hit
//   fetches again and marks the run's words.
//   After reset all frames read as used: a clearing pass writes ones to every
//   word, during which s_axis_tready_o is low.
//   A finished result sits in an output register; the next command is taken
//   while it waits, and that command stalls only at its own result until
//   the receiver drains m_axis.
// ----------------------------------------------------------------------------
module bitmap_frame_allocator #(
  parameter int unsigned NUM_FRAMES = 32768
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid_i,
  output logic        s_axis_tready_o,
  input  logic [31:0] s_axis_tdata_i,   // [14:0] frame_number, [30:15] frame_count
  input  logic [2:0]  s_axis_tuser_i,   // [2:0] command
  output logic        m_axis_tvalid_o,
  input  logic        m_axis_tready_i,
  output logic [15:0] m_axis_tdata_o,   // [14:0] result_frame
  output logic        m_axis_tuser_o,   // [0] found
  input  logic        cfg_valid_i,
  output logic        cfg_ready_o,
  input  logic        cfg_index_i,
  input  logic [15:0] cfg_data_i
);
  import bfa_pkg::*;

  localparam int unsigned FW    = $clog2(NUM_FRAMES + 1);
  localparam int unsigned HW    = (FW > 16) ? FW : 16;
  localparam int unsigned WORDS = (NUM_FRAMES + 31) / 32;
  localparam int unsigned AW    = $clog2(WORDS);

  localparam logic [HW-1:0] NUM_H   = HW'(NUM_FRAMES);
  localparam logic [AW-1:0] LAST_WD = AW'(WORDS - 1);

  state_e state_q, state_d;
  state_e go_q, go_d;
  cmd_e   cmd_q, cmd_d;

  logic [HW-1:0] lhint_q, lhint_d, hhint_q, hhint_d;
  logic [15:0]   lend_q, lend_d;
  logic [AW-1:0] cur_q, cur_d, last_q, last_d;
  logic [4:0]    pstart_q, pstart_d;
  logic          first_q, first_d;
  logic [HW-1:0] bound_q, bound_d;
  logic [HW-1:0] run_q, run_d, start_q, start_d;
  logic [15:0]   need_q, need_d;
  logic          set_q, set_d;
  logic [14:0]   res_frame_q, res_frame_d;
  logic          res_found_q, res_found_d;
  logic          m_valid_q, m_valid_d;
  logic [14:0]   m_frame_q, m_frame_d;
  logic          m_found_q, m_found_d;

  logic              wr_en, rd_en;
  logic [AW-1:0]     wr_addr, rd_addr;
  logic [WORD_W-1:0] wr_data, rd_data;

  // input decode
  cmd_e          cmd_in;
  logic [14:0]   fn_in;
  logic [15:0]   cnt_in, rng_cnt;
  logic [HW-1:0] fn_h, lend_h, llim, hs, end_in;
  logic [HW:0]   fn_sum;
  logic          s_acc, lo_ok, hi_ok, rng_ok, in_go;

  // word walk
  logic [HW-1:0]     base;
  logic [4:0]        pbit;
  logic              at_last;
  logic [5:0]        hi_n;
  logic [WORD_W-1:0] free_m, rng_m;
  scan_res_t         scan;
  logic [5:0]        prefix_len;
  logic [HW:0]       run_pre;
  logic              prefix_hit, run_hit, single_hit, resp_load;
  logic [HW-1:0]     run_start, run_end, single_pos;

  assign cmd_in  = cmd_e'(s_axis_tuser_i);
  assign fn_in   = s_axis_tdata_i[14:0];
  assign cnt_in  = s_axis_tdata_i[30:15];
  assign s_acc   = s_axis_tvalid_i && s_axis_tready_o;
  assign fn_h    = HW'(fn_in);
  assign lend_h  = HW'(lend_q);
  assign llim    = (lend_h < NUM_H) ? lend_h : NUM_H;
  assign rng_cnt = (cmd_in == CMD_FREE) ? 16'd1 : cnt_in;
  assign fn_sum  = (HW+1)'(fn_h) + (HW+1)'(rng_cnt);
  assign end_in  = (fn_sum < (HW+1)'(NUM_H)) ? fn_sum[HW-1:0] : NUM_H;
  assign hs      = (fn_h > lend_h) ? fn_h : lend_h;
  assign lo_ok   = lhint_q < llim;
  assign hi_ok   = hhint_q < NUM_H;
  assign rng_ok  = (fn_h < NUM_H) && (rng_cnt != 16'd0);

  always_comb begin
    case (cmd_in)
      CMD_ALLOC_LOW:  in_go = lo_ok;
      CMD_ALLOC_HIGH: in_go = hi_ok;
      CMD_ALLOC_RUN:  in_go = lo_ok && (cnt_in != 16'd0);
      CMD_FREE, CMD_FREE_RUN, CMD_MARK_FREE, CMD_MARK_USED: in_go = rng_ok;
      default:        in_go = 1'b0;
    endcase
  end

  assign base    = HW'({cur_q, 5'b0});
  assign pbit    = first_q ? pstart_q : 5'd0;
  assign at_last = (cur_q == last_q);
  assign hi_n    = at_last ? 6'(bound_q - base) : 6'd32;
  assign rng_m   = low_mask(hi_n) & ~low_mask({1'b0, pbit});
  assign free_m  = ~rd_data & rng_m;

  bfa_word_scan u_scan (
    .free_i (free_m),
    .pbit_i (pbit),
    .need_i (need_q),
    .res_o  (scan)
  );

  assign single_hit = !scan.ff_pos[5];
  assign single_pos = base + HW'(scan.ff_pos[4:0]);
  assign prefix_len = scan.fu_pos - {1'b0, pbit};
  assign run_pre    = (HW+1)'(run_q) + (HW+1)'(prefix_len);
  assign prefix_hit = run_pre >= (HW+1)'(need_q);
  assign run_hit    = prefix_hit || scan.win_hit;
  assign run_start  = prefix_hit ? start_q : (base + HW'(scan.win_pos));
  assign run_end    = run_start + HW'(need_q);
  assign resp_load  = !m_valid_q || m_axis_tready_i;

  bfa_bitmap_ram #(
    .DEPTH (WORDS),
    .AW    (AW)
  ) u_ram (
    .clk_i     (clk_i),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_en_i   (rd_en),
    .rd_addr_i (rd_addr),
    .rd_data_o (rd_data)
  );

  // next state
  always_comb begin
    state_d = state_q;
    case (state_q)
      ST_CLEAR:  if (cur_q == LAST_WD) state_d = ST_IDLE;
      ST_IDLE:   if (s_acc) state_d = in_go ? ST_FETCH : ST_RESP;
      ST_FETCH:  state_d = go_q;
      ST_SINGLE: if (single_hit || at_last) state_d = ST_RESP;
      ST_RUN: begin
        if (run_hit) begin
          state_d = ST_FETCH;
        end else if (at_last) begin
          state_d = ST_RESP;
        end
      end
      ST_MARK:   if (at_last) state_d = ST_RESP;
      ST_RESP:   if (resp_load) state_d = ST_IDLE;
      default:   state_d = ST_IDLE;
    endcase
  end

  // datapath and memory control
  always_comb begin
    go_d        = go_q;
    cmd_d       = cmd_q;
    lhint_d     = lhint_q;
    hhint_d     = hhint_q;
    lend_d      = lend_q;
    cur_d       = cur_q;
    last_d      = last_q;
    pstart_d    = pstart_q;
    first_d     = first_q;
    bound_d     = bound_q;
    run_d       = run_q;
    start_d     = start_q;
    need_d      = need_q;
    set_d       = set_q;
    res_frame_d = res_frame_q;
    res_found_d = res_found_q;
    m_valid_d   = m_valid_q && !m_axis_tready_i;
    m_frame_d   = m_frame_q;
    m_found_d   = m_found_q;
    rd_en       = 1'b0;
    rd_addr     = cur_q;
    wr_en       = 1'b0;
    wr_addr     = cur_q;
    wr_data     = rd_data;

    case (state_q)
      ST_CLEAR: begin
        wr_en   = 1'b1;
        wr_data = '1;
        cur_d   = cur_q + AW'(1);
      end
      ST_IDLE: begin
        if (s_acc) begin
          cmd_d       = cmd_in;
          res_frame_d = '0;
          res_found_d = 1'b0;
          first_d     = 1'b1;
          case (cmd_in)
            CMD_ALLOC_LOW, CMD_ALLOC_RUN: begin
              go_d     = (cmd_in == CMD_ALLOC_RUN) ? ST_RUN : ST_SINGLE;
              cur_d    = lhint_q[AW+4:5];
              pstart_d = lhint_q[4:0];
              bound_d  = llim;
              last_d   = AW'(HW'(llim - HW'(1)) >> 5);
              run_d    = '0;
              start_d  = lhint_q;
              need_d   = cnt_in;
            end
            CMD_ALLOC_HIGH: begin
              go_d     = ST_SINGLE;
              cur_d    = hhint_q[AW+4:5];
              pstart_d = hhint_q[4:0];
              bound_d  = NUM_H;
              last_d   = LAST_WD;
            end
            CMD_FREE, CMD_FREE_RUN, CMD_MARK_FREE, CMD_MARK_USED: begin
              go_d     = ST_MARK;
              cur_d    = fn_h[AW+4:5];
              pstart_d = fn_h[4:0];
              bound_d  = end_in;
              last_d   = AW'(HW'(end_in - HW'(1)) >> 5);
              set_d    = (cmd_in == CMD_MARK_USED);
              // freeing pulls hints back to the lowest freed frame per arena
              if (rng_ok && (cmd_in == CMD_FREE || cmd_in == CMD_FREE_RUN)) begin
                if (fn_h < lend_h && fn_h < lhint_q) begin
                  lhint_d = fn_h;
                end
                if (hs < end_in && hs < hhint_q) begin
                  hhint_d = hs;
                end
              end
            end
            default: ;
          endcase
        end
      end
      ST_FETCH: begin
        rd_en = 1'b1;
      end
      ST_SINGLE: begin
        if (single_hit) begin
          wr_en       = 1'b1;
          wr_data     = rd_data | (WORD_W'(1) << scan.ff_pos[4:0]);
          res_frame_d = single_pos[14:0];
          res_found_d = 1'b1;
          if (cmd_q == CMD_ALLOC_LOW) begin
            lhint_d = single_pos;
          end else begin
            hhint_d = single_pos;
          end
        end else if (at_last) begin
          if (cmd_q == CMD_ALLOC_LOW) begin
            lhint_d = bound_q;
          end else begin
            hhint_d = bound_q;
          end
        end else begin
          rd_en   = 1'b1;
          rd_addr = cur_q + AW'(1);
          cur_d   = cur_q + AW'(1);
          first_d = 1'b0;
        end
      end
      ST_RUN: begin
        if (run_hit) begin
          go_d        = ST_MARK;
          res_frame_d = run_start[14:0];
          res_found_d = 1'b1;
          cur_d       = run_start[AW+4:5];
          pstart_d    = run_start[4:0];
          bound_d     = run_end;
          last_d      = AW'(HW'(run_end - HW'(1)) >> 5);
          first_d     = 1'b1;
          set_d       = 1'b1;
          if (run_start == lhint_q) begin
            lhint_d = lhint_q + HW'(need_q);
          end
        end else begin
          if (scan.fu_pos[5]) begin
            run_d = run_q + HW'(6'd32 - {1'b0, pbit});
          end else begin
            run_d   = HW'(scan.top_run);
            start_d = base + HW'(6'd32 - scan.top_run);
          end
          if (!at_last) begin
            rd_en   = 1'b1;
            rd_addr = cur_q + AW'(1);
            cur_d   = cur_q + AW'(1);
            first_d = 1'b0;
          end
        end
      end
      ST_MARK: begin
        wr_en   = 1'b1;
        wr_data = set_q ? (rd_data | rng_m) : (rd_data & ~rng_m);
        if (!at_last) begin
          rd_en   = 1'b1;
          rd_addr = cur_q + AW'(1);
          cur_d   = cur_q + AW'(1);
          first_d = 1'b0;
        end
      end
      ST_RESP: begin
        if (resp_load) begin
          m_valid_d = 1'b1;
          m_frame_d = res_frame_q;
          m_found_d = res_found_q;
        end
      end
      default: ;
    endcase

    if (cfg_valid_i) begin
      if (cfg_index_i == REG_LOW_START) begin
        lhint_d = HW'(cfg_data_i);
      end else begin
        lend_d  = cfg_data_i;
        hhint_d = HW'(cfg_data_i);
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= ST_CLEAR;
      go_q      <= ST_MARK;
      cur_q     <= '0;
      lhint_q   <= HW'(RST_LOW_START);
      hhint_q   <= HW'(RST_LOW_END);
      lend_q    <= RST_LOW_END;
      m_valid_q <= 1'b0;
    end else begin
      state_q   <= state_d;
      go_q      <= go_d;
      cur_q     <= cur_d;
      lhint_q   <= lhint_d;
      hhint_q   <= hhint_d;
      lend_q    <= lend_d;
      m_valid_q <= m_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    cmd_q       <= cmd_d;
    last_q      <= last_d;
    pstart_q    <= pstart_d;
    first_q     <= first_d;
    bound_q     <= bound_d;
    run_q       <= run_d;
    start_q     <= start_d;
    need_q      <= need_d;
    set_q       <= set_d;
    res_frame_q <= res_frame_d;
    res_found_q <= res_found_d;
    m_frame_q   <= m_frame_d;
    m_found_q   <= m_found_d;
  end

  assign s_axis_tready_o = (state_q == ST_IDLE);
  assign m_axis_tvalid_o = m_valid_q;
  assign m_axis_tdata_o  = {1'b0, m_frame_q};
  assign m_axis_tuser_o  = m_found_q;
  assign cfg_ready_o     = 1'b1;

  a_no_rw_same_word: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (rd_en && wr_en) |-> (rd_addr != wr_addr))
    else $error("read and write of the same bitmap word in one cycle");

  a_idle_no_write: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_IDLE || state_q == ST_RESP) |-> !wr_en)
    else $error("bitmap written outside a command walk");

  a_accept_leaves_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_acc |=> (state_q == ST_FETCH || state_q == ST_RESP))
    else $error("accepted command did not start");

  a_walk_in_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_SINGLE || state_q == ST_RUN || state_q == ST_MARK)
      |-> (cur_q <= last_q))
    else $error("word walk passed its last word");

  a_result_has_slot: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RESP && m_valid_q && !m_axis_tready_i) |=> (state_q == ST_RESP))
    else $error("result dropped while output stalled");

endmodule

FILE: test/tb_bitmap_frame_allocator.sv
// ----------------------------------------------------------------------------
// tb_bitmap_frame_allocator: self-checking bench of the bitmap frame allocator
// Directed commands, then random command mixes over several arena settings,
// with random idling on both stream sides. Each result is checked against a
// bitmap tracker that keeps its own frame bits, hints and arena bounds.
// ----------------------------------------------------------------------------
module tb_bitmap_frame_allocator;
  import bfa_pkg::*;

  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned FRAMES     = 32768;
  localparam logic [2:0]  CMD_UNUSED = 3'd7;
  localparam int unsigned MAX_CYCLES = 30_000_000;

  localparam logic [15:0] ARENA_START [5] = '{16'd256, 16'd0, 16'd32768, 16'd64, 16'd300};
  localparam logic [15:0] ARENA_END [5]   = '{16'd4096, 16'd32768, 16'd0, 16'd1024, 16'd2000};

  typedef struct {
    logic [14:0] frame;
    logic        found;
  } grant_t;

  class frame_allocation_tracker;
    bit          used_bits[FRAMES];
    int unsigned low_hint, high_hint, low_start, low_end;
    grant_t      pending_grants[$];
    int          errors;

    function void init();
      foreach (used_bits[i]) used_bits[i] = 1'b1;
      low_start = RST_LOW_START;
      low_end   = RST_LOW_END;
      low_hint  = low_start;
      high_hint = low_end;
      errors    = 0;
    endfunction

    function void write_reg(logic idx, logic [15:0] val);
      if (idx == REG_LOW_START) begin
        low_start = val;
        low_hint  = val;
      end else begin
        low_end   = val;
        high_hint = val;
      end
    endfunction

    function bit is_used(int unsigned f);
      return (f >= FRAMES) ? 1'b1 : used_bits[f];
    endfunction

    function void set_bit(int unsigned f, bit v);
      if (f < FRAMES) used_bits[f] = v;
    endfunction

    function void release_frame(int unsigned f);
      if (f >= FRAMES) return;
      if (f < low_end) begin
        if (f < low_hint) low_hint = f;
      end else if (f < high_hint) begin
        high_hint = f;
      end
      used_bits[f] = 1'b0;
    endfunction

    function void note_command(logic [2:0] cmd, logic [14:0] fn, logic [15:0] cnt);
      int unsigned lim, res, start, run, need;
      bit ok;
      grant_t g;
      lim = (low_end < FRAMES) ? low_end : FRAMES;
      res = 0;
      ok  = 1'b0;
      need = cnt;
      case (cmd)
        CMD_ALLOC_LOW: begin
          for (; low_hint < lim; low_hint++) begin
            if (!is_used(low_hint)) begin
              set_bit(low_hint, 1'b1);
              res = low_hint;
              ok  = 1'b1;
              break;
            end
          end
        end
        CMD_ALLOC_HIGH: begin
          for (; high_hint < FRAMES; high_hint++) begin
            if (!is_used(high_hint)) begin
              set_bit(high_hint, 1'b1);
              res = high_hint;
              ok  = 1'b1;
              break;
            end
          end
        end
        CMD_ALLOC_RUN: begin
          start = low_hint;
          run   = 0;
          if (need != 0) begin
            for (int unsigned c = low_hint; c < lim; c++) begin
              if (is_used(c)) begin
                run   = 0;
                start = c + 1;
              end else begin
                run++;
              end
              if (run >= need) begin
                for (int unsigned i = 0; i < need; i++) set_bit(start + i, 1'b1);
                if (start == low_hint) low_hint += need;
                res = start;
                ok  = 1'b1;
                break;
              end
            end
          end
        end
        CMD_FREE: release_frame(fn);
        CMD_FREE_RUN:
          for (int unsigned i = 0; i < need && fn + i < FRAMES; i++) release_frame(fn + i);
        CMD_MARK_FREE:
          for (int unsigned i = 0; i < need && fn + i < FRAMES; i++) set_bit(fn + i, 1'b0);
        CMD_MARK_USED:
          for (int unsigned i = 0; i < need && fn + i < FRAMES; i++) set_bit(fn + i, 1'b1);
        default: ;
      endcase
      g.frame = ok ? res[14:0] : 15'd0;
      g.found = ok;
      pending_grants.push_back(g);
    endfunction

    function void check_result(logic [14:0] frame, logic found);
      grant_t g;
      if (pending_grants.size() == 0) begin
        $error("result with no command outstanding: frame %0d found %0d", frame, found);
        errors++;
        return;
      end
      g = pending_grants.pop_front();
      if (frame !== g.frame) begin
        $error("result_frame expected %0d actual %0d", g.frame, frame);
        errors++;
      end
      if (found !== g.found) begin
        $error("found expected %0d actual %0d", g.found, found);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid_i = 1'b0;
  logic        s_axis_tready_o;
  logic [31:0] s_axis_tdata_i = '0;
  logic [2:0]  s_axis_tuser_i = '0;
  logic        m_axis_tvalid_o;
  logic        m_axis_tready_i = 1'b0;
  logic [15:0] m_axis_tdata_o;
  logic        m_axis_tuser_o;
  logic        cfg_valid_i = 1'b0;
  logic        cfg_ready_o;
  logic        cfg_index_i = 1'b0;
  logic [15:0] cfg_data_i = '0;

  frame_allocation_tracker tracker;
  int unsigned tx_idle_pct, rx_idle_pct;
  longint unsigned cycle_count = 0;

  bitmap_frame_allocator #(.NUM_FRAMES(FRAMES)) u_dut (.*);

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count > MAX_CYCLES) begin
      $display("FAIL");
      $finish;
    end
  end

  // result side: check on the sampled handshake, then pick the next ready
  always @(posedge clk_i) begin
    if (rst_ni && m_axis_tvalid_o && m_axis_tready_i)
      tracker.check_result(m_axis_tdata_o[14:0], m_axis_tuser_o);
    m_axis_tready_i <= ($urandom_range(0, 99) >= rx_idle_pct);
  end

  task automatic send_command(logic [2:0] cmd, logic [14:0] fn, logic [15:0] cnt);
    while ($urandom_range(0, 99) < tx_idle_pct) begin
      s_axis_tvalid_i <= 1'b0;
      @(posedge clk_i);
    end
    s_axis_tvalid_i <= 1'b1;
    s_axis_tuser_i  <= cmd;
    s_axis_tdata_i  <= {1'b0, cnt, fn};
    do @(posedge clk_i); while (!s_axis_tready_o);
    tracker.note_command(cmd, fn, cnt);
  endtask

  task automatic write_reg(logic idx, logic [15:0] val);
    cfg_valid_i <= 1'b1;
    cfg_index_i <= idx;
    cfg_data_i  <= val;
    do @(posedge clk_i); while (!cfg_ready_o);
    tracker.write_reg(idx, val);
    cfg_valid_i <= 1'b0;
    @(posedge clk_i);
  endtask

  task automatic drain();
    s_axis_tvalid_i <= 1'b0;
    while (tracker.pending_grants.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
  endtask

  // mostly commands aimed at the arenas, some full-range noise
  task automatic send_random();
    int unsigned pick, lo, hi;
    logic [2:0]  cmd;
    logic [14:0] fn;
    logic [15:0] cnt;
    pick = $urandom_range(0, 99);
    lo = (tracker.low_start > 64) ? tracker.low_start - 64 : 0;
    if (lo > FRAMES - 1) lo = FRAMES - 1;
    hi = (tracker.low_end + 256 < FRAMES) ? tracker.low_end + 256 : FRAMES - 1;
    if (lo > hi) lo = 0;
    fn  = 15'($urandom_range(lo, hi));
    cnt = 16'($urandom_range(1, 48));
    if (pick < 20) cmd = CMD_ALLOC_LOW;
    else if (pick < 30) cmd = CMD_ALLOC_HIGH;
    else if (pick < 45) begin
      cmd = CMD_ALLOC_RUN;
      cnt = ($urandom_range(0, 19) == 0) ? 16'($urandom_range(0, 32768))
                                         : 16'($urandom_range(1, 8));
    end else if (pick < 65) cmd = CMD_FREE;
    else if (pick < 78) cmd = CMD_FREE_RUN;
    else if (pick < 88) cmd = CMD_MARK_FREE;
    else if (pick < 96) cmd = CMD_MARK_USED;
    else begin
      cmd = ($urandom_range(0, 1) == 0) ? CMD_UNUSED : 3'($urandom_range(3, 6));
      fn  = 15'($urandom);
      cnt = 16'($urandom_range(0, 32768));
    end
    send_command(cmd, fn, cnt);
  endtask

  initial begin
    tracker = new();
    tracker.init();
    tx_idle_pct = 16;
    rx_idle_pct = 45;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed part at reset arena settings
    send_command(CMD_MARK_FREE, 15'd0, 16'd8192);
    send_command(CMD_ALLOC_LOW, 15'd0, 16'd0);
    send_command(CMD_ALLOC_HIGH, 15'd0, 16'd0);
    send_command(CMD_ALLOC_RUN, 15'd0, 16'd0);
    send_command(CMD_ALLOC_RUN, 15'd0, 16'd5);
    send_command(CMD_ALLOC_RUN, 15'd0, 16'd32768);
    send_command(CMD_FREE, 15'd300, 16'd0);
    send_command(CMD_FREE, 15'h7fff, 16'hffff);
    send_command(CMD_FREE_RUN, 15'd32760, 16'd100);
    send_command(CMD_MARK_FREE, 15'h7fff, 16'd32768);
    send_command(CMD_MARK_USED, 15'd0, 16'd32768);
    send_command(CMD_ALLOC_LOW, 15'd0, 16'd0);   // fails, hint runs to the limit
    send_command(CMD_ALLOC_HIGH, 15'd0, 16'd0);
    send_command(CMD_MARK_FREE, 15'd16384, 16'd16384);
    send_command(CMD_ALLOC_HIGH, 15'd0, 16'd0);
    send_command(CMD_FREE, 15'd10, 16'd0);       // pulls low hint below arena start
    send_command(CMD_ALLOC_LOW, 15'd0, 16'd0);
    send_command(CMD_UNUSED, 15'h5555, 16'haaaa);
    send_command(CMD_FREE_RUN, 15'd4090, 16'd12); // straddles the arena bound
    send_command(CMD_ALLOC_RUN, 15'd0, 16'd3);
    send_command(CMD_ALLOC_HIGH, 15'd0, 16'd0);

    for (int ph = 0; ph < 5; ph++) begin
      if (ph > 0) begin
        drain();
        write_reg(REG_LOW_START, ARENA_START[ph]);
        write_reg(REG_LOW_END, ARENA_END[ph]);
        send_command(CMD_MARK_FREE, 15'($urandom_range(0, 2048)), 16'd512);
      end
      tx_idle_pct = (ph < 2) ? 16 : (ph < 4) ? 45 : 0;
      rx_idle_pct = (ph < 2) ? 45 : (ph < 4) ? 16 : 0;
      repeat (215) send_random();
    end

    drain();
    repeat (40) @(posedge clk_i);
    if (tracker.pending_grants.size() != 0) begin
      $error("%0d results never arrived", tracker.pending_grants.size());
      tracker.errors++;
    end
    if (tracker.errors == 0) $display("PASS");
    else $display("FAIL");
    $finish;
  end
endmodule

FILE: filelist.f
hdl/bfa_pkg.sv
hdl/bfa_bitmap_ram.sv
hdl/bfa_word_scan.sv
hdl/bitmap_frame_allocator.sv
test/tb_bitmap_frame_allocator.sv
